@@ hw/rtl/tclc_pkg.sv @@
// Shared types, constants and the power-table generator for the two-channel lux calculator.
// Depends on nothing; every other file in hw/rtl imports it.
package tclc_pkg;

    localparam int unsigned POW_TABLE_DEPTH_DEF = 64;

    // Divider: one quotient bit per cell over a 17-bit ratio
    localparam int unsigned DIV_STEPS = 17;
    localparam int unsigned RATIO_W   = 17;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 17'd131071;

    // Ratio breakpoints, Q1.16
    localparam logic [RATIO_W-1:0] BP_050 = 17'd32768;
    localparam logic [RATIO_W-1:0] BP_061 = 17'd39977;
    localparam logic [RATIO_W-1:0] BP_080 = 17'd52429;
    localparam logic [RATIO_W-1:0] BP_130 = 17'd85197;

    // Coefficients, Q0.24
    localparam int unsigned COEF_W = 20;
    localparam logic [COEF_W-1:0] K_0304  = 20'd510027;
    localparam logic [COEF_W-1:0] K_062   = 20'd1040187;
    localparam logic [COEF_W-1:0] K_0224  = 20'd375810;
    localparam logic [COEF_W-1:0] K_031   = 20'd520094;
    localparam logic [COEF_W-1:0] K_0128  = 20'd214748;
    localparam logic [COEF_W-1:0] K_0153  = 20'd256691;
    localparam logic [COEF_W-1:0] K_00146 = 20'd24495;
    localparam logic [COEF_W-1:0] K_00112 = 20'd18790;

    localparam int unsigned PROD_W = COEF_W + 16;
    localparam int unsigned LUX_W  = 19;
    localparam logic [LUX_W-1:0] LUX_MAX = 19'd524287;

    typedef enum logic [2:0] {
        BAND_ZERO = 3'd0,
        BAND_LOW  = 3'd1,
        BAND_MID  = 3'd2,
        BAND_HIGH = 3'd3,
        BAND_TOP  = 3'd4,
        BAND_OVER = 3'd5
    } t_band;

    // Word travelling down the divider chain
    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic                 sat;
        logic                 nbit;
        logic [15:0]          ch0;
        logic [15:0]          ch1;
        logic [15:0]          rem;
        logic [RATIO_W-1:0]   q;
    } t_div_word;

    // Per-word data carried alongside the power interpolation
    typedef struct packed {
        t_band               band;
        logic                zero;
        logic [15:0]         ch0;
        logic [PROD_W-1:0]   lin_pos;
        logic [PROD_W-1:0]   lin_neg;
    } t_side;

    // floor(65536 * (k / (2*depth))^1.4), exact: largest y with
    // y^5 * (2*depth)^7 <= k^7 * 2^80
    function automatic logic [15:0] pow_entry(input int unsigned k, input int unsigned depth);
        logic [191:0] lhs;
        logic [191:0] rhs;
        logic [191:0] scale;
        logic [191:0] kp;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        int           i;
        lo    = 0;
        hi    = 65535;
        scale = 192'd1;
        kp    = 192'd1;
        for (i = 0; i < 7; i++) begin
            scale = scale * 192'(2 * depth);
            kp    = kp * 192'(k);
        end
        rhs = kp << 80;
        for (i = 0; i < 17; i++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                lhs = 192'(mid) * 192'(mid);
                lhs = lhs * lhs * 192'(mid);
                lhs = lhs * scale;
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        return 16'(lo);
    endfunction

endpackage

@@ hw/rtl/tclc_div_cell.sv @@
// One cell of the restoring divider chain: one quotient bit, then register.
// Depends on tclc_pkg.
module tclc_div_cell
    import tclc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_word i_word,
    output t_div_word o_word
);

    logic [16:0] w_shift;
    logic        w_ge;
    t_div_word   n_word;
    t_div_word   r_word;

    always_comb begin
        w_shift     = {i_word.rem, i_word.nbit};
        w_ge        = (w_shift >= {1'b0, i_word.ch0});
        n_word      = i_word;
        n_word.nbit = 1'b0;
        n_word.rem  = w_ge ? 16'(w_shift - {1'b0, i_word.ch0}) : w_shift[15:0];
        n_word.q    = {i_word.q[RATIO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

@@ hw/rtl/tclc_pow_interp.sv @@
// ratio^1.4 over (0, 0.5] by linear interpolation in a constant table, three stages.
// Depends on tclc_pkg (pow_entry, t_side).
module tclc_pow_interp
    import tclc_pkg::*;
#(
    parameter int unsigned POW_TABLE_DEPTH = POW_TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_ratio,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [15:0] o_y,
    output t_side       o_side
);

    localparam int unsigned SEG_W = $clog2(POW_TABLE_DEPTH + 1);
    localparam int unsigned T_W   = 16 + SEG_W;
    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(POW_TABLE_DEPTH);

    logic [15:0] w_tab [0:POW_TABLE_DEPTH];

    for (genvar k = 0; k <= POW_TABLE_DEPTH; k++) begin : g_tab
        assign w_tab[k] = pow_entry(k, POW_TABLE_DEPTH);
    end

    // Stage A: scale ratio into segment and fraction
    logic [T_W-1:0]   w_t;
    logic             r_a_valid;
    logic [SEG_W-1:0] r_a_seg;
    logic [14:0]      r_a_frac;
    t_side            r_a_side;

    assign w_t = T_W'(i_ratio) * T_W'(POW_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        r_a_seg  <= w_t[15 +: SEG_W];
        r_a_frac <= w_t[14:0];
        r_a_side <= i_side;
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    // Stage B: fetch both knots; hold the last knot at the end of the table
    logic [SEG_W-1:0] w_nseg;
    logic             r_b_valid;
    logic [15:0]      r_b_base;
    logic [15:0]      r_b_next;
    logic [14:0]      r_b_frac;
    t_side            r_b_side;

    assign w_nseg = (r_a_seg == SEG_LAST) ? r_a_seg : r_a_seg + 1'b1;

    always_ff @(posedge i_clk) begin
        r_b_base <= w_tab[r_a_seg];
        r_b_next <= w_tab[w_nseg];
        r_b_frac <= r_a_frac;
        r_b_side <= r_a_side;
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    // Stage C: base + slope * frac
    logic [15:0] w_next;
    logic [15:0] w_delta;
    logic [30:0] w_step;
    logic        r_c_valid;
    logic [15:0] r_c_y;
    t_side       r_c_side;

    assign w_next  = (r_b_next < r_b_base) ? r_b_base : r_b_next;
    assign w_delta = w_next - r_b_base;
    assign w_step  = 31'(w_delta) * 31'(r_b_frac);

    always_ff @(posedge i_clk) begin
        r_c_y    <= r_b_base + w_step[30:15];
        r_c_side <= r_b_side;
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    assign o_valid = r_c_valid;
    assign o_y     = r_c_y;
    assign o_side  = r_c_side;

endmodule

@@ hw/rtl/tclc_lux_eval.sv @@
// Lux equations for all bands, band select and saturation; four stages ending in the output register.
// Depends on tclc_pkg.
module tclc_lux_eval
    import tclc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [15:0]      i_y,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [LUX_W-1:0] o_lux_q8,
    output logic             o_zero_channel,
    output logic [2:0]       o_band
);

    localparam logic [34:0] K_POS_LOW = {K_0304[18:0], 16'd0};

    // Stage 1: infrared term of the low band; finish the linear bands
    logic [PROD_W-1:0] w_lin_dif;
    logic [LUX_W-1:0]  w_lin;
    logic              r1_valid;
    logic [PROD_W-1:0] r1_mk;
    logic [LUX_W-1:0]  r1_lin;
    t_band             r1_band;
    logic              r1_zero;
    logic [15:0]       r1_ch0;

    always_comb begin
        w_lin_dif = i_side.lin_pos - i_side.lin_neg;
        if (i_side.lin_pos <= i_side.lin_neg) begin
            w_lin = '0;
        end else if (w_lin_dif[PROD_W-1:16] > (PROD_W-16)'(LUX_MAX)) begin
            w_lin = LUX_MAX;
        end else begin
            w_lin = w_lin_dif[16 +: LUX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mk   <= PROD_W'(K_062) * PROD_W'(i_y);
        r1_lin  <= w_lin;
        r1_band <= i_side.band;
        r1_zero <= i_side.zero;
        r1_ch0  <= i_side.ch0;
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    // Stage 2: coefficient difference, sign kept apart
    logic [PROD_W:0]  w_kdif;
    logic             r2_valid;
    logic             r2_pos;
    logic [34:0]      r2_kdif;
    logic [LUX_W-1:0] r2_lin;
    t_band            r2_band;
    logic             r2_zero;
    logic [15:0]      r2_ch0;

    assign w_kdif = (PROD_W+1)'(K_POS_LOW) - (PROD_W+1)'(r1_mk);

    always_ff @(posedge i_clk) begin
        r2_pos  <= !w_kdif[PROD_W] && (w_kdif != '0);
        r2_kdif <= w_kdif[34:0];
        r2_lin  <= r1_lin;
        r2_band <= r1_band;
        r2_zero <= r1_zero;
        r2_ch0  <= r1_ch0;
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    // Stage 3: scale by ch0, drop 32 fraction bits
    logic [50:0]      w_prod;
    logic             r3_valid;
    logic [LUX_W-1:0] r3_low;
    logic [LUX_W-1:0] r3_lin;
    t_band            r3_band;
    logic             r3_zero;

    assign w_prod = 51'(r2_ch0) * 51'(r2_kdif);

    always_ff @(posedge i_clk) begin
        r3_low  <= r2_pos ? w_prod[32 +: LUX_W] : '0;
        r3_lin  <= r2_lin;
        r3_band <= r2_band;
        r3_zero <= r2_zero;
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    // Stage 4: pick by band into the output register
    logic [LUX_W-1:0] n_lux;
    logic             r4_valid;
    logic [LUX_W-1:0] r4_lux;
    t_band            r4_band;
    logic             r4_zero;

    always_comb begin
        case (r3_band)
            BAND_LOW:  n_lux = r3_low;
            BAND_MID:  n_lux = r3_lin;
            BAND_HIGH: n_lux = r3_lin;
            BAND_TOP:  n_lux = r3_lin;
            default:   n_lux = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r4_lux  <= n_lux;
        r4_band <= r3_band;
        r4_zero <= r3_zero;
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    assign o_valid        = r4_valid;
    assign o_lux_q8       = r4_lux;
    assign o_zero_channel = r4_zero;
    assign o_band         = r4_band;

endmodule

@@ hw/rtl/two_channel_lux_calculator.sv @@
// Two-channel lux calculator: a word (ch0, ch1) in, one lux word out.
// From start to o_valid a word passes 17 divider cells, one band stage,
// three interpolation stages and four equation stages. Throughput one word per
// cycle, set by the divider chain producing one quotient bit per cell.
// busy stays low; the receiver cannot stall, each result shows for one cycle.
// Reset (i_rst_n low, synchronous) empties the pipeline; no words are in flight.
module two_channel_lux_calculator
    import tclc_pkg::*;
#(
    parameter int unsigned POW_TABLE_DEPTH = POW_TABLE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [15:0]      i_ch0_count,
    input  logic [15:0]      i_ch1_count,
    output logic             o_valid,
    output logic [LUX_W-1:0] o_lux_q8,
    output logic             o_zero_channel,
    output logic [2:0]       o_band
);

    // Every stage advances every cycle, so a new word is always welcome.
    assign busy = 1'b0;

    // Divider head. ratio = floor(ch1 * 2^16 / ch0); it saturates exactly
    // when ch1 >= 2*ch0, i.e. floor(ch1/2) >= ch0. Otherwise the partial
    // remainder starts at floor(ch1/2), and the cells shift in ch1[0]
    // followed by sixteen zeros to form the 17 quotient bits.
    t_div_word w_head;
    t_div_word w_chain [0:DIV_STEPS];

    always_comb begin
        w_head.valid = start && !busy;
        w_head.zero  = (i_ch0_count == '0);
        w_head.sat   = ({1'b0, i_ch1_count[15:1]} >= i_ch0_count);
        w_head.nbit  = i_ch1_count[0];
        w_head.ch0   = i_ch0_count;
        w_head.ch1   = i_ch1_count;
        w_head.rem   = {1'b0, i_ch1_count[15:1]};
        w_head.q     = '0;
    end

    assign w_chain[0] = w_head;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        tclc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_chain[i]),
            .o_word  (w_chain[i+1])
        );
    end

    // Band stage: pick the band, form both products of the linear bands,
    // and clamp the ratio to the table's range for the power path.
    t_div_word          w_tail;
    logic [RATIO_W-1:0] w_ratio;
    t_band              w_band;
    logic [COEF_W-1:0]  w_ka;
    logic [COEF_W-1:0]  w_kb;
    t_side              n_side;
    logic [15:0]        n_pow_ratio;

    assign w_tail  = w_chain[DIV_STEPS];
    assign w_ratio = w_tail.sat ? RATIO_MAX : w_tail.q;

    always_comb begin
        if (w_tail.zero || w_ratio == '0) begin
            w_band = BAND_ZERO;
        end else if (w_ratio <= BP_050) begin
            w_band = BAND_LOW;
        end else if (w_ratio <= BP_061) begin
            w_band = BAND_MID;
        end else if (w_ratio <= BP_080) begin
            w_band = BAND_HIGH;
        end else if (w_ratio <= BP_130) begin
            w_band = BAND_TOP;
        end else begin
            w_band = BAND_OVER;
        end

        case (w_band)
            BAND_MID: begin
                w_ka = K_0224;
                w_kb = K_031;
            end
            BAND_HIGH: begin
                w_ka = K_0128;
                w_kb = K_0153;
            end
            BAND_TOP: begin
                w_ka = K_00146;
                w_kb = K_00112;
            end
            default: begin
                w_ka = '0;
                w_kb = '0;
            end
        endcase

        n_side.band    = w_band;
        n_side.zero    = w_tail.zero;
        n_side.ch0     = w_tail.ch0;
        n_side.lin_pos = PROD_W'(w_ka) * PROD_W'(w_tail.ch0);
        n_side.lin_neg = PROD_W'(w_kb) * PROD_W'(w_tail.ch1);

        // Only the lowest band reads the power; cap at 0.5 so the segment
        // index never runs past the last knot.
        n_pow_ratio = (w_ratio > BP_050) ? BP_050[15:0] : w_ratio[15:0];
    end

    logic        r_e_valid;
    logic [15:0] r_e_ratio;
    t_side       r_e_side;

    always_ff @(posedge i_clk) begin
        r_e_ratio <= n_pow_ratio;
        r_e_side  <= n_side;
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= w_tail.valid;
        end
    end

    // Power interpolation, side data travels with it
    logic        w_p_valid;
    logic [15:0] w_p_y;
    t_side       w_p_side;

    tclc_pow_interp #(
        .POW_TABLE_DEPTH (POW_TABLE_DEPTH)
    ) u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_valid),
        .i_ratio (r_e_ratio),
        .i_side  (r_e_side),
        .o_valid (w_p_valid),
        .o_y     (w_p_y),
        .o_side  (w_p_side)
    );

    // Equations, selection and the output register
    tclc_lux_eval u_eval (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_p_valid),
        .i_y            (w_p_y),
        .i_side         (w_p_side),
        .o_valid        (o_valid),
        .o_lux_q8       (o_lux_q8),
        .o_zero_channel (o_zero_channel),
        .o_band         (o_band)
    );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for two_channel_lux_calculator: directed and random channel-count
// pairs, with every lux word checked against a predictor held inside the bench.
// Depends on tclc_pkg (band codes, lux width) and the RTL top level.
`timescale 1ns / 100ps

module tb_top;
    import tclc_pkg::*;

    // Power-table depth handed to the block; the predictor builds its own knots for it
    localparam int unsigned KNOTS_DEPTH = 64;

    localparam int unsigned PIPE_LATENCY = 25;
    localparam int unsigned DRAIN_CYCLES = PIPE_LATENCY + 15;
    localparam int unsigned RANDOM_PAIRS = 630;
    // Worst case is about 650 words, each behind the longest gap draw_gap returns; take several times that
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // Ratio breakpoints in Q1.16
    localparam logic [16:0] RATIO_BP_LOW  = 17'd32768;
    localparam logic [16:0] RATIO_BP_MID  = 17'd39977;
    localparam logic [16:0] RATIO_BP_HIGH = 17'd52429;
    localparam logic [16:0] RATIO_BP_OVER = 17'd85197;
    localparam logic [16:0] RATIO_CEIL    = 17'd131071;

    // Equation coefficients in Q0.24: A scales ch0, B scales the ch1 term
    localparam logic [19:0] COEF_A_LOW  = 20'd510027;
    localparam logic [19:0] COEF_B_LOW  = 20'd1040187;
    localparam logic [19:0] COEF_A_MID  = 20'd375810;
    localparam logic [19:0] COEF_B_MID  = 20'd520094;
    localparam logic [19:0] COEF_A_HIGH = 20'd214748;
    localparam logic [19:0] COEF_B_HIGH = 20'd256691;
    localparam logic [19:0] COEF_A_TOP  = 20'd24495;
    localparam logic [19:0] COEF_B_TOP  = 20'd18790;

    localparam logic [63:0] LUX_CEIL = 64'd524287;

    typedef struct {
        logic [15:0] ch0;
        logic [15:0] ch1;
    } t_count_pair;

    typedef struct {
        logic [LUX_W-1:0] lux;
        logic             zero;
        t_band            band;
    } t_lux_word;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [15:0]      i_ch0_count = 16'd0;
    logic [15:0]      i_ch1_count = 16'd0;
    logic             o_valid;
    logic [LUX_W-1:0] o_lux_q8;
    logic             o_zero_channel;
    logic [2:0]       o_band;

    // Pairs waiting to be driven, and lux words owed by the block, oldest first
    t_count_pair pending_pairs[$];
    t_lux_word   lux_owed[$];

    logic [15:0] knot_y [0:KNOTS_DEPTH];

    int unsigned pairs_sent = 0;
    int unsigned directed_pairs = 0;
    int unsigned words_checked = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned band_seen [0:5];
    int unsigned zero_flags = 0;
    int unsigned cycle_cnt = 0;

    // Idle cycles before the next word, and words left in a run with no idling
    int unsigned idle_left = 0;
    int unsigned burst_left = 0;

    two_channel_lux_calculator #(
        .POW_TABLE_DEPTH (KNOTS_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_ch0_count    (i_ch0_count),
        .i_ch1_count    (i_ch1_count),
        .o_valid        (o_valid),
        .o_lux_q8       (o_lux_q8),
        .o_zero_channel (o_zero_channel),
        .o_band         (o_band)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Largest y with (y/65536)^5 <= x^7 at x = k/(2*depth), found bit by bit from the top.
    // Everything is scaled to integers: y^5 * (2*depth)^7 <= k^7 * 2^80.
    function automatic logic [15:0] knot_power(input int unsigned k);
        logic [191:0] span7;
        logic [191:0] bound;
        logic [191:0] y5;
        logic [15:0]  y;
        logic [15:0]  cand;
        int           i;
        int           b;
        span7 = 192'd1;
        bound = 192'd1;
        for (i = 0; i < 7; i++) begin
            span7 = span7 * 192'(2 * KNOTS_DEPTH);
            bound = bound * 192'(k);
        end
        bound = bound << 80;
        y = 16'd0;
        for (b = 15; b >= 0; b--) begin
            cand = y | (16'd1 << b);
            y5 = 192'd1;
            for (i = 0; i < 5; i++) begin
                y5 = y5 * 192'(cand);
            end
            if (y5 * span7 <= bound) begin
                y = cand;
            end
        end
        return y;
    endfunction

    // floor(ch1 * 2^16 / ch0), held at the Q1.16 ceiling; ch0 of zero is handled by the caller
    function automatic logic [16:0] ratio_q16(input logic [15:0] c0, input logic [15:0] c1);
        logic [31:0] q;
        if (c0 == 16'd0) begin
            return RATIO_CEIL;
        end
        q = {c1, 16'h0000} / {16'h0000, c0};
        return (q > 32'(RATIO_CEIL)) ? RATIO_CEIL : q[16:0];
    endfunction

    // ratio^1.4 in Q0.16, linear between knots; the last knot stands for the end point
    function automatic logic [31:0] interp_pow(input logic [16:0] r);
        logic [31:0] t;
        logic [31:0] seg;
        logic [31:0] frac;
        logic [31:0] lo_y;
        logic [31:0] hi_y;
        t    = 32'(r) * KNOTS_DEPTH;
        seg  = t >> 15;
        frac = t & 32'h7FFF;
        if (seg >= KNOTS_DEPTH) begin
            return 32'(knot_y[KNOTS_DEPTH]);
        end
        lo_y = 32'(knot_y[seg]);
        hi_y = 32'(knot_y[seg + 1]);
        if (hi_y < lo_y) begin
            hi_y = lo_y;
        end
        return lo_y + (((hi_y - lo_y) * frac) >> 15);
    endfunction

    function automatic t_lux_word predict_lux(input logic [15:0] c0, input logic [15:0] c1);
        t_lux_word   w;
        logic [16:0] r;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] lux;
        w.lux  = '0;
        w.zero = 1'b0;
        w.band = BAND_ZERO;
        pos    = 64'd0;
        neg    = 64'd0;
        lux    = 64'd0;
        if (c0 == 16'd0) begin
            w.zero = 1'b1;
            return w;
        end
        r = ratio_q16(c0, c1);
        if (r == 17'd0) begin
            w.band = BAND_ZERO;
        end else if (r <= RATIO_BP_LOW) begin
            w.band = BAND_LOW;
            pos = (64'(COEF_A_LOW) * 64'(c0)) << 16;
            neg = 64'(COEF_B_LOW) * 64'(c0) * 64'(interp_pow(r));
            lux = (pos > neg) ? (pos - neg) >> 32 : 64'd0;
        end else if (r <= RATIO_BP_OVER) begin
            if (r <= RATIO_BP_MID) begin
                w.band = BAND_MID;
                pos = 64'(COEF_A_MID) * 64'(c0);
                neg = 64'(COEF_B_MID) * 64'(c1);
            end else if (r <= RATIO_BP_HIGH) begin
                w.band = BAND_HIGH;
                pos = 64'(COEF_A_HIGH) * 64'(c0);
                neg = 64'(COEF_B_HIGH) * 64'(c1);
            end else begin
                w.band = BAND_TOP;
                pos = 64'(COEF_A_TOP) * 64'(c0);
                neg = 64'(COEF_B_TOP) * 64'(c1);
            end
            lux = (pos > neg) ? (pos - neg) >> 16 : 64'd0;
        end else begin
            w.band = BAND_OVER;
        end
        if (lux > LUX_CEIL) begin
            lux = LUX_CEIL;
        end
        w.lux = lux[LUX_W-1:0];
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_pair(input logic [15:0] c0, input logic [15:0] c1);
        t_count_pair p;
        p.ch0 = c0;
        p.ch1 = c1;
        pending_pairs.push_back(p);
    endtask

    // ch1 giving a ratio at or just above the target for this ch0, held at full scale
    function automatic logic [15:0] ch1_for_ratio(input logic [16:0] target,
                                                  input logic [15:0] c0);
        logic [47:0] num;
        logic [47:0] c1;
        num = 48'(target) * 48'(c0);
        c1  = (num + 48'd65535) >> 16;
        return (c1 > 48'd65535) ? 16'hFFFF : c1[15:0];
    endfunction

    // Search down from full-scale ch0 for a pair that lands on the ratio exactly
    task automatic queue_exact_ratio(input logic [16:0] target);
        int unsigned c0;
        logic [15:0] c1;
        for (c0 = 65535; c0 >= 1; c0--) begin
            c1 = ch1_for_ratio(target, c0[15:0]);
            if (ratio_q16(c0[15:0], c1) == target) begin
                queue_pair(c0[15:0], c1);
                return;
            end
        end
    endtask

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int unsigned draw_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) begin
            return 0;
        end else if (p < 85) begin
            return $urandom_range(1, 3);
        end else if (p < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_cnt++;
        $display("[%0t] lux word %0d: %s mismatch, got %0d expected %0d",
                 $realtime, words_checked, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: pop the next pair once the current word has been taken (start high, busy low),
    // predict the lux word at that same edge, and hold off for the drawn gap.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_words
        t_count_pair nxt;
        if (!i_rst_n) begin
            start      <= 1'b0;
            idle_left  <= 0;
            burst_left <= 0;
        end else if (!(start && busy)) begin
            if (start) begin
                lux_owed.push_back(predict_lux(i_ch0_count, i_ch1_count));
                pairs_sent++;
            end
            if (idle_left > 0) begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (pending_pairs.size() > 0) begin
                nxt = pending_pairs.pop_front();
                i_ch0_count <= nxt.ch0;
                i_ch1_count <= nxt.ch1;
                start       <= 1'b1;
                // Inside a burst, keep start high word after word
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                    idle_left  <= 0;
                end else begin
                    idle_left <= draw_gap();
                    if ($urandom_range(0, 24) == 0) begin
                        burst_left <= $urandom_range(15, 60);
                    end
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each strobed lux word is held for one cycle only, so take it at the edge
    // that ends that cycle and compare with the oldest owed word.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_words
        t_lux_word want;
        if (i_rst_n && o_valid) begin
            if (lux_owed.size() == 0) begin
                report_mismatch("unexpected word, lux", o_lux_q8, 0);
            end else begin
                want = lux_owed.pop_front();
                if (o_lux_q8 !== want.lux) begin
                    report_mismatch("lux_q8", o_lux_q8, want.lux);
                end
                if (o_zero_channel !== want.zero) begin
                    report_mismatch("zero_channel", o_zero_channel, want.zero);
                end
                if (o_band !== want.band) begin
                    report_mismatch("band", o_band, want.band);
                end
                if (want.band <= BAND_OVER) begin
                    band_seen[want.band]++;
                end
                if (want.zero) begin
                    zero_flags++;
                end
            end
            words_checked++;
        end
    end

    // Watchdog: drop the run if it never drains
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d lux words still owed",
                     cycle_cnt, lux_owed.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build the knots, queue directed then random pairs, reset, drain, report
    // ------------------------------------------------------------------
    initial begin : run_sequence
        int unsigned   k;
        int unsigned   n;
        int unsigned   pick;
        int            spread;
        logic [16:0]   target;
        logic [15:0]   c0;
        logic [16:0]   edges [0:3];

        for (k = 0; k < 6; k++) begin
            band_seen[k] = 0;
        end
        for (k = 0; k <= KNOTS_DEPTH; k++) begin
            knot_y[k] = knot_power(k);
        end
        edges[0] = RATIO_BP_LOW;
        edges[1] = RATIO_BP_MID;
        edges[2] = RATIO_BP_HIGH;
        edges[3] = RATIO_BP_OVER;

        // Zero ch0 forces zero and raises the flag, whatever ch1 holds
        queue_pair(16'd0, 16'd0);
        queue_pair(16'd0, 16'hFFFF);
        // Zero ratio from a zero ch1
        queue_pair(16'hFFFF, 16'd0);
        queue_pair(16'd1, 16'd0);
        // Smallest non-zero ratio, and the brightest lowest-band reading
        queue_pair(16'hFFFF, 16'd1);
        queue_pair(16'hFFFF, 16'd100);
        // Ratio held at its ceiling, far above the top breakpoint
        queue_pair(16'd1, 16'hFFFF);
        queue_pair(16'h5555, 16'hAAAA);
        // Unity ratio at both ends of the count range
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(16'd1, 16'd1);
        // Ratio of exactly one half, where interpolation runs off the last knot, and just below it
        queue_pair(16'hAAAA, 16'h5555);
        queue_pair(16'd2, 16'd1);
        queue_pair(16'hFFFF, 16'd32767);
        // Every breakpoint on the nose and one step beyond
        for (k = 0; k < 4; k++) begin
            queue_exact_ratio(edges[k]);
            queue_exact_ratio(edges[k] + 17'd1);
        end
        directed_pairs = pending_pairs.size();

        for (n = 0; n < RANDOM_PAIRS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                queue_pair(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end else if (pick < 65) begin
                // Ratio spread over the live bands
                target = 17'($urandom_range(1, 88000));
                c0     = 16'($urandom_range(1, 65535));
                queue_pair(c0, ch1_for_ratio(target, c0));
            end else if (pick < 85) begin
                // Hug a breakpoint
                spread = int'($urandom_range(0, 600));
                target = edges[2'($urandom_range(0, 3))] + 17'(spread) - 17'd300;
                c0     = 16'($urandom_range(1, 65535));
                queue_pair(c0, ch1_for_ratio(target, c0));
            end else if (pick < 93) begin
                queue_pair(16'($urandom_range(1, 64)), 16'($urandom_range(0, 64)));
            end else if (pick < 97) begin
                queue_pair(16'd0, 16'($urandom_range(0, 65535)));
            end else begin
                queue_pair(16'($urandom_range(1, 65535)), 16'd0);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample at the falling edge so the queues have settled
        @(negedge i_clk);
        while (pending_pairs.size() != 0 || start || lux_owed.size() != 0) begin
            @(negedge i_clk);
        end
        // Keep watching for stray words past the pipeline depth
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d channel pairs (%0d directed, rest random), %0d lux words checked",
                 pairs_sent, directed_pairs, words_checked);
        $display("Bands zero/low/mid/high/top/over: %0d/%0d/%0d/%0d/%0d/%0d, zero-ch0 %0d",
                 band_seen[0], band_seen[1], band_seen[2], band_seen[3], band_seen[4],
                 band_seen[5], zero_flags);
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
